>>> rtl/core/lfsp_pkg.sv
// Package for the lidar frame scan packetizer: sizes, codes, item and result types.
// It has no dependencies. The front, the back and the top level use it.
`timescale 1ns / 1ps
package lfsp_pkg;
	localparam int MAX_FRAMES        = 64;
	localparam int FRAME_BYTES       = 58;
	localparam int FRAMES_PER_PACKET = 20;
	localparam int HEADER_LEN        = 14;
	localparam int BANK_BYTES        = MAX_FRAMES * FRAME_BYTES;
	localparam int STORE_DEPTH       = 2 * BANK_BYTES;
	localparam int ADDR_W            = $clog2(STORE_DEPTH);
	localparam int FPOS_W            = $clog2(FRAME_BYTES + 1);
	localparam int FB_IDX_W          = $clog2(FRAME_BYTES);
	localparam int FILL_W            = $clog2(MAX_FRAMES + 1);
	localparam int PKT_CNT_MAX       = (MAX_FRAMES + FRAMES_PER_PACKET - 1) / FRAMES_PER_PACKET;
	localparam int PCNT_W            = $clog2(PKT_CNT_MAX + 1);
	localparam int PLEN_MAX          = HEADER_LEN + FRAMES_PER_PACKET * FRAME_BYTES;
	localparam int OFF_W             = $clog2(PLEN_MAX + 1);
	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;
	localparam logic [15:0] THRESHOLD_RESET = 16'd18000;
	localparam logic [1:0] REG_SEND_ENABLE   = 2'd0;
	localparam logic [1:0] REG_WRAP_THRESHOLD = 2'd1;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STORED  = 3'd1,
		EV_CLOSED  = 3'd2,
		EV_DROPPED = 3'd3,
		EV_BAD_SUM = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_READ
	} state_t;

	typedef struct packed {
		logic       is_pull;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		event_t     ev;
		logic       overrun;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       packet_end;
		logic       scan_end;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h4E;
			2'd1:    r = 8'h31;
			2'd2:    r = 8'h30;
			default: r = 8'h53;
		endcase
		return r;
	endfunction

	function automatic logic [PCNT_W-1:0] pkt_count(input logic [FILL_W-1:0] n);
		logic [PCNT_W-1:0] r;
		r = PCNT_W'(PKT_CNT_MAX);
		for (int k = PKT_CNT_MAX; k >= 0; k--) begin
			if (k * FRAMES_PER_PACKET >= int'(n)) begin
				r = PCNT_W'(k);
			end
		end
		return r;
	endfunction
endpackage

>>> rtl/core/lfsp_front.sv
// Front part: accepts items, classifies them as received bytes or pulls, and queues them.
// It depends on lfsp_pkg.
`timescale 1ns / 1ps
module lfsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic            command,
	input  logic [7:0]      data_byte,
	output logic            item_valid,
	output lfsp_pkg::item_t item,
	input  logic            item_take
);
	lfsp_pkg::item_t q_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = q_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wptr_q].is_pull <= command;
			q_q[wptr_q].data    <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

>>> rtl/core/lfsp_back.sv
// Back part: frame hunt, checksum, scan store with two banks, packet drain and result queue.
// It depends on lfsp_pkg.
`timescale 1ns / 1ps
module lfsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  lfsp_pkg::item_t   item,
	output logic              item_take,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              res_pop,
	output logic              res_empty,
	output lfsp_pkg::result_t res
);
	localparam int AW = lfsp_pkg::ADDR_W;
	localparam int FW = lfsp_pkg::FILL_W;
	localparam int PW = lfsp_pkg::FPOS_W;
	localparam int OW = lfsp_pkg::OFF_W;
	localparam int CW = lfsp_pkg::PCNT_W;
	localparam int IW = lfsp_pkg::FB_IDX_W;

	lfsp_pkg::state_t state_q, state_d;

	logic [7:0] fb_mem [lfsp_pkg::FRAME_BYTES];
	logic [7:0] store_mem [lfsp_pkg::STORE_DEPTH];
	logic [7:0] fb_rdata_q;
	logic [7:0] st_rdata_q;

	logic          send_en_q;
	logic [15:0]   thr_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    sum_q;
	logic [7:0]    ang_hi_q;
	logic [7:0]    ang_lo_q;
	logic [15:0]   last_q;
	logic          seen_q;
	logic [FW-1:0] fill_q;
	logic          bank_q;
	logic [31:0]   scan_q;
	logic          pend_q;
	logic [31:0]   id_q;
	logic [FW-1:0] left_q;
	logic [CW-1:0] pkt_q;
	logic [CW-1:0] count_q;
	logic [OW-1:0] off_q;
	logic [AW-1:0] raddr_q;
	logic [PW-1:0] cp_q;
	logic [AW-1:0] waddr_q;
	logic          wr_s1;

	lfsp_pkg::result_t oq_q [2];
	logic       owp_q;
	logic       orp_q;
	logic [1:0] ocnt_q;
	logic       opush;
	logic       opop;
	lfsp_pkg::result_t ores;

	logic          start;
	logic          is_byte;
	logic [7:0]    b;
	logic          fb_we;
	logic [IW-1:0] fb_waddr;
	logic [PW-1:0] pos_d;
	logic [7:0]    sum_d;
	logic          frame_done;
	logic          sum_ok;
	logic [15:0]   angle;
	logic          close;
	logic          hand;
	logic [FW-1:0] fill_eff;
	logic          store_ok;
	logic          bank_next;
	logic [AW-1:0] base;

	logic [FW-1:0] in_pkt;
	logic [OW:0]   pkt_len;
	logic          last_byte;
	logic          last_pkt;
	logic [7:0]    obyte;
	logic [15:0]   pkt16;
	logic [15:0]   cnt16;
	logic [15:0]   inp16;

	assign start     = (state_q == lfsp_pkg::ST_IDLE) && item_valid && (ocnt_q != 2'd2);
	assign item_take = start;
	assign is_byte   = start && !item.is_pull;
	assign b         = item.data;

	always_comb begin
		fb_we      = 1'b0;
		fb_waddr   = pos_q[IW-1:0];
		pos_d      = pos_q;
		sum_d      = sum_q;
		frame_done = 1'b0;
		if (pos_q == '0) begin
			if (b == lfsp_pkg::SYNC_FIRST) begin
				fb_we    = 1'b1;
				fb_waddr = '0;
				sum_d    = b;
				pos_d    = PW'(1);
			end
		end else if (pos_q == PW'(1)) begin
			if (b == lfsp_pkg::SYNC_SECOND) begin
				fb_we    = 1'b1;
				fb_waddr = IW'(1);
				sum_d    = sum_q + b;
				pos_d    = PW'(2);
			end else if (b == lfsp_pkg::SYNC_FIRST) begin
				fb_we    = 1'b1;
				fb_waddr = '0;
				sum_d    = b;
			end else begin
				pos_d = '0;
			end
		end else begin
			fb_we = 1'b1;
			if (pos_q < PW'(lfsp_pkg::FRAME_BYTES - 1)) begin
				sum_d = sum_q + b;
			end
			pos_d = pos_q + PW'(1);
			if (pos_q == PW'(2) && b != 8'(lfsp_pkg::FRAME_BYTES)) begin
				pos_d = '0;
			end else if (pos_q == PW'(lfsp_pkg::FRAME_BYTES - 1)) begin
				frame_done = 1'b1;
				pos_d      = '0;
			end
		end
	end

	assign sum_ok    = (sum_q == b);
	assign angle     = {ang_hi_q, ang_lo_q};
	assign close     = seen_q && (({1'b0, angle} + {1'b0, thr_q}) < {1'b0, last_q});
	assign hand      = close && (fill_q != '0) && send_en_q;
	assign fill_eff  = close ? '0 : fill_q;
	assign store_ok  = fill_eff < FW'(lfsp_pkg::MAX_FRAMES);
	assign bank_next = hand ? ~bank_q : bank_q;
	assign base      = (bank_next ? AW'(lfsp_pkg::BANK_BYTES) : '0)
		+ AW'(int'(fill_eff) * lfsp_pkg::FRAME_BYTES);

	assign in_pkt    = (left_q > FW'(lfsp_pkg::FRAMES_PER_PACKET)) ?
		FW'(lfsp_pkg::FRAMES_PER_PACKET) : left_q;
	assign pkt_len   = (OW + 1)'(lfsp_pkg::HEADER_LEN)
		+ (OW + 1)'(int'(in_pkt) * lfsp_pkg::FRAME_BYTES);
	assign last_byte = ({1'b0, off_q} + (OW + 1)'(1)) >= pkt_len;
	assign last_pkt  = ({1'b0, pkt_q} + (CW + 1)'(1)) >= {1'b0, count_q};
	assign pkt16     = 16'(pkt_q);
	assign cnt16     = 16'(count_q);
	assign inp16     = 16'(in_pkt);

	always_comb begin
		if (off_q < OW'(4)) begin
			obyte = lfsp_pkg::magic_byte(off_q[1:0]);
		end else if (off_q < OW'(8)) begin
			obyte = id_q[8 * off_q[1:0] +: 8];
		end else if (off_q < OW'(10)) begin
			obyte = pkt16[8 * off_q[0] +: 8];
		end else if (off_q < OW'(12)) begin
			obyte = cnt16[8 * off_q[0] +: 8];
		end else if (off_q < OW'(lfsp_pkg::HEADER_LEN)) begin
			obyte = inp16[8 * off_q[0] +: 8];
		end else begin
			obyte = st_rdata_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfsp_pkg::ST_IDLE: begin
				if (start) begin
					if (item.is_pull) begin
						if (pend_q) begin
							state_d = lfsp_pkg::ST_READ;
						end
					end else if (frame_done && sum_ok && store_ok) begin
						state_d = lfsp_pkg::ST_COPY;
					end
				end
			end
			lfsp_pkg::ST_COPY: begin
				if (cp_q == PW'(lfsp_pkg::FRAME_BYTES - 1)) begin
					state_d = lfsp_pkg::ST_IDLE;
				end
			end
			lfsp_pkg::ST_READ: state_d = lfsp_pkg::ST_IDLE;
			default: state_d = lfsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		opush = 1'b0;
		ores  = '0;
		unique case (state_q)
			lfsp_pkg::ST_IDLE: begin
				if (start) begin
					if (!item.is_pull) begin
						opush = 1'b1;
						if (frame_done) begin
							if (!sum_ok) begin
								ores.ev = lfsp_pkg::EV_BAD_SUM;
							end else begin
								ores.overrun = hand && pend_q;
								if (!store_ok) begin
									ores.ev = lfsp_pkg::EV_DROPPED;
								end else if (close) begin
									ores.ev = lfsp_pkg::EV_CLOSED;
								end else begin
									ores.ev = lfsp_pkg::EV_STORED;
								end
							end
						end
					end else if (!pend_q) begin
						opush = 1'b1;
					end
				end
			end
			lfsp_pkg::ST_READ: begin
				opush           = 1'b1;
				ores.out_valid  = 1'b1;
				ores.out_byte   = obyte;
				ores.packet_end = last_byte;
				ores.scan_end   = last_byte && last_pkt;
			end
			default: begin
				opush = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (is_byte && fb_we) begin
			fb_mem[fb_waddr] <= b;
		end
		fb_rdata_q <= fb_mem[cp_q[IW-1:0]];
		if (wr_s1) begin
			store_mem[waddr_q] <= fb_rdata_q;
		end
		st_rdata_q <= store_mem[raddr_q];
		if (is_byte && pos_q == PW'(5)) begin
			ang_hi_q <= b;
		end
		if (is_byte && pos_q == PW'(6)) begin
			ang_lo_q <= b;
		end
		if (opush) begin
			oq_q[owp_q] <= ores;
		end
	end

	assign opop      = res_pop && (ocnt_q != 2'd0);
	assign res_empty = (ocnt_q == 2'd0);
	assign res       = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lfsp_pkg::ST_IDLE;
			send_en_q <= 1'b0;
			thr_q     <= lfsp_pkg::THRESHOLD_RESET;
			pos_q     <= '0;
			sum_q     <= '0;
			last_q    <= '0;
			seen_q    <= 1'b0;
			fill_q    <= '0;
			bank_q    <= 1'b0;
			scan_q    <= '0;
			pend_q    <= 1'b0;
			id_q      <= '0;
			left_q    <= '0;
			pkt_q     <= '0;
			count_q   <= '0;
			off_q     <= '0;
			raddr_q   <= '0;
			cp_q      <= '0;
			waddr_q   <= '0;
			wr_s1     <= 1'b0;
			owp_q     <= 1'b0;
			orp_q     <= 1'b0;
			ocnt_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == lfsp_pkg::REG_SEND_ENABLE) begin
				send_en_q <= cfg_data[0];
			end
			if (cfg_we && cfg_index == lfsp_pkg::REG_WRAP_THRESHOLD) begin
				thr_q <= cfg_data;
			end
			wr_s1 <= (state_q == lfsp_pkg::ST_COPY);
			if (state_q == lfsp_pkg::ST_COPY) begin
				cp_q <= cp_q + PW'(1);
			end else begin
				cp_q <= '0;
			end
			if (is_byte) begin
				pos_q <= pos_d;
				sum_q <= sum_d;
			end
			if (is_byte && frame_done && sum_ok) begin
				waddr_q <= base;
				last_q  <= angle;
				seen_q  <= 1'b1;
				fill_q  <= store_ok ? fill_eff + FW'(1) : fill_eff;
				bank_q  <= bank_next;
				if (close) begin
					scan_q <= scan_q + 32'd1;
				end
				if (hand) begin
					pend_q  <= 1'b1;
					id_q    <= scan_q;
					left_q  <= fill_q;
					count_q <= lfsp_pkg::pkt_count(fill_q);
					pkt_q   <= '0;
					off_q   <= '0;
					raddr_q <= bank_q ? AW'(lfsp_pkg::BANK_BYTES) : '0;
				end
			end else if (wr_s1) begin
				waddr_q <= waddr_q + AW'(1);
			end
			if (state_q == lfsp_pkg::ST_READ) begin
				if (off_q >= OW'(lfsp_pkg::HEADER_LEN)) begin
					raddr_q <= raddr_q + AW'(1);
				end
				if (last_byte) begin
					off_q  <= '0;
					pkt_q  <= pkt_q + CW'(1);
					left_q <= left_q - in_pkt;
					if (last_pkt) begin
						pend_q <= 1'b0;
					end
				end else begin
					off_q <= off_q + OW'(1);
				end
			end
			if (opush) begin
				owp_q <= ~owp_q;
			end
			if (opop) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};
		end
	end
endmodule

>>> rtl/core/lidar_frame_scan_packetizer.sv
// Top level of the lidar frame scan packetizer: front item queue and back sequencer.
// It depends on lfsp_pkg, lfsp_front and lfsp_back.
//
// Items enter through push/full: command 0 carries a received serial byte in data_byte,
// command 1 pulls one byte of the outgoing packet stream. Every item yields exactly one
// result, read in order through empty/pop from the result ports.
// Configuration is written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 is send_enable, index 1 is wrap_threshold.
// A received byte is handled in the state that accepts it, so its result can be popped
// in the cycle after the item is accepted. The last byte of a frame that is stored also
// keeps the sequencer busy while the frame buffer is copied into the scan store through
// its single write port. A pull passes through the read state while a scan waits to be
// drained, and is answered in the state that accepts it when nothing is pending.
// The two-entry queues on both sides let input and output stall independently; when the
// receiver stops popping, the result queue fills and then the input queue fills and full
// rises. Reset clears all control state and needs no clearing pass: only written store
// entries are ever read. After reset send_enable is 0 and wrap_threshold is 18000.
`timescale 1ns / 1ps
module lidar_frame_scan_packetizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_res,
	output logic        overrun,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        packet_end,
	output logic        scan_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic              item_valid;
	lfsp_pkg::item_t   item;
	logic              item_take;
	lfsp_pkg::result_t res;

	assign cfg_ready = 1'b1;

	lfsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.data_byte  (data_byte),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	lfsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_pop    (pop),
		.res_empty  (empty),
		.res        (res)
	);

	assign event_res  = res.ev;
	assign overrun    = res.overrun;
	assign out_valid  = res.out_valid;
	assign out_byte   = res.out_byte;
	assign packet_end = res.packet_end;
	assign scan_end   = res.scan_end;
endmodule
